### hw/rtl/lr_pkg.sv
// Shared constants for the line rasterizer.
package lr_pkg;

    localparam int unsigned COORD_BITS_DEF = 12;
    localparam int unsigned CANVAS_BITS    = 12;
    localparam int unsigned CFG_IDX_BITS   = 1;

    localparam logic [CANVAS_BITS-1:0] CANVAS_WIDTH_RST  = 12'd640;
    localparam logic [CANVAS_BITS-1:0] CANVAS_HEIGHT_RST = 12'd480;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_CANVAS_WIDTH  = 1'b0,
        CFG_CANVAS_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef enum logic {
        MODE_TICK = 1'b0,
        MODE_LOAD = 1'b1
    } t_mode;

endpackage

### hw/rtl/line_rasterizer_unit.sv
// Line rasterizer top level: canvas registers, front end, queue and pixel stepper.
// A tick beat's pixel passes through the queue and the output register.
// One beat per cycle while the queue has room; one major step per cycle unless stalled.
// A load beat gives no pixel; a tick with no line in progress gives none.
// Reset (synchronous, active low) empties the queue, drops any line and
// returns the canvas to 640 by 480.
module line_rasterizer_unit
    import lr_pkg::*;
#(
    parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // start_x, start_y, end_x, end_y, zero pad
    input  logic [((4*COORD_BITS+7)/8)*8-1:0]     i_s_tdata,
    // mode
    input  logic                                  i_s_tuser,
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    // pixel_x, pixel_y, inside_res, all_inside, zero pad
    output logic [((2*COORD_BITS+2+7)/8)*8-1:0]   o_m_tdata,
    output logic                                  o_m_tlast,
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]               i_cfg_index,
    input  logic [CANVAS_BITS-1:0]                i_cfg_data
);

    localparam int unsigned C     = COORD_BITS;
    localparam int unsigned CMD_W = 5 * C + 6;
    localparam int unsigned OW    = ((2 * C + 2 + 7) / 8) * 8;

    logic [CANVAS_BITS-1:0] r_width, r_height;
    logic [CMD_W-1:0]       f_cmd, q_cmd;
    logic                   q_valid, q_ready;
    logic signed [C-1:0]    px, py;
    logic                   p_in, p_all;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= CANVAS_WIDTH_RST;
            r_height <= CANVAS_HEIGHT_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_CANVAS_WIDTH:  r_width  <= i_cfg_data;
                CFG_CANVAS_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    lr_front #(.COORD_BITS(C), .CMD_W(CMD_W)) u_front (
        .i_mode    (i_s_tuser),
        .i_start_x (i_s_tdata[C-1:0]),
        .i_start_y (i_s_tdata[2*C-1:C]),
        .i_end_x   (i_s_tdata[3*C-1:2*C]),
        .i_end_y   (i_s_tdata[4*C-1:3*C]),
        .o_cmd     (f_cmd)
    );

    lr_fifo #(.W(CMD_W)) u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (i_s_tvalid),
        .o_wr_ready (o_s_tready),
        .i_wr_data  (f_cmd),
        .o_rd_valid (q_valid),
        .i_rd_ready (q_ready),
        .o_rd_data  (q_cmd)
    );

    lr_back #(.COORD_BITS(C), .CMD_W(CMD_W)) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_canvas_width  (r_width),
        .i_canvas_height (r_height),
        .i_cmd_valid     (q_valid),
        .o_cmd_ready     (q_ready),
        .i_cmd           (q_cmd),
        .o_valid         (o_m_tvalid),
        .i_ready         (i_m_tready),
        .o_pixel_x       (px),
        .o_pixel_y       (py),
        .o_inside_res    (p_in),
        .o_all_inside    (p_all),
        .o_last          (o_m_tlast)
    );

    assign o_m_tdata = OW'({p_all, p_in, py, px});

endmodule

### hw/rtl/lr_front.sv
// Front end: classifies input beats and prepares line setup words.
module lr_front
    import lr_pkg::*;
#(
    parameter int unsigned COORD_BITS = COORD_BITS_DEF,
    parameter int unsigned CMD_W      = 5 * COORD_BITS + 6
) (
    input  logic                         i_mode,
    input  logic signed [COORD_BITS-1:0] i_start_x,
    input  logic signed [COORD_BITS-1:0] i_start_y,
    input  logic signed [COORD_BITS-1:0] i_end_x,
    input  logic signed [COORD_BITS-1:0] i_end_y,
    output logic [CMD_W-1:0]             o_cmd
);

    localparam int unsigned C = COORD_BITS;

    logic signed [C:0]   dx, dy, maj_d, min_d;
    logic [C:0]          adx, ady;
    logic                steep, swap, is_load;
    logic signed [C-1:0] a_s, a_e, b_s, b_e;
    logic signed [C-1:0] maj_s, maj_e, min_s, min_e;
    logic [C+1:0]        step2, span2;

    always_comb begin
        is_load = (t_mode'(i_mode) == MODE_LOAD);
        dx  = $signed({i_end_x[C-1], i_end_x}) - $signed({i_start_x[C-1], i_start_x});
        dy  = $signed({i_end_y[C-1], i_end_y}) - $signed({i_start_y[C-1], i_start_y});
        adx = dx[C] ? (~dx + 1'b1) : dx;
        ady = dy[C] ? (~dy + 1'b1) : dy;
        steep = (ady > adx);
        if (steep) begin
            a_s = i_start_y; a_e = i_end_y; b_s = i_start_x; b_e = i_end_x;
        end else begin
            a_s = i_start_x; a_e = i_end_x; b_s = i_start_y; b_e = i_end_y;
        end
        swap = !(a_s < a_e);
        maj_s = swap ? a_e : a_s;
        maj_e = swap ? a_s : a_e;
        min_s = swap ? b_e : b_s;
        min_e = swap ? b_s : b_e;
        maj_d = $signed({maj_e[C-1], maj_e}) - $signed({maj_s[C-1], maj_s});
        min_d = $signed({min_e[C-1], min_e}) - $signed({min_s[C-1], min_s});
        step2 = {min_d, 1'b0};
        span2 = {maj_d, 1'b0};
        if (is_load) begin
            o_cmd = {1'b1, steep, maj_s, maj_e, min_s, step2, span2};
        end else begin
            o_cmd = '0;
        end
    end

endmodule

### hw/rtl/lr_fifo.sv
// Two-entry queue between front and back end.
module lr_fifo
    import lr_pkg::*;
#(
    parameter int unsigned W = 5 * COORD_BITS_DEF + 6
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_wr_valid,
    output logic         o_wr_ready,
    input  logic [W-1:0] i_wr_data,
    output logic         o_rd_valid,
    input  logic         i_rd_ready,
    output logic [W-1:0] o_rd_data
);

    logic [W-1:0] r_mem [2];
    logic         r_wp, r_rp;
    logic [1:0]   r_cnt;
    logic         push, pop;

    assign o_wr_ready = (r_cnt != 2'd2);
    assign o_rd_valid = (r_cnt != 2'd0);
    assign o_rd_data  = r_mem[r_rp];
    assign push       = i_wr_valid && o_wr_ready;
    assign pop        = o_rd_valid && i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_wr_data;
    end

endmodule

### hw/rtl/lr_back.sv
// Back end: steps along the line with an incremental remainder and emits pixels.
module lr_back
    import lr_pkg::*;
#(
    parameter int unsigned COORD_BITS = COORD_BITS_DEF,
    parameter int unsigned CMD_W      = 5 * COORD_BITS + 6
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [CANVAS_BITS-1:0]       i_canvas_width,
    input  logic [CANVAS_BITS-1:0]       i_canvas_height,
    input  logic                         i_cmd_valid,
    output logic                         o_cmd_ready,
    input  logic [CMD_W-1:0]             i_cmd,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [COORD_BITS-1:0] o_pixel_x,
    output logic signed [COORD_BITS-1:0] o_pixel_y,
    output logic                         o_inside_res,
    output logic                         o_all_inside,
    output logic                         o_last
);

    localparam int unsigned C   = COORD_BITS;
    localparam int unsigned NW  = 2 * C + 3;
    localparam int unsigned CW  = ((C > CANVAS_BITS) ? C : CANVAS_BITS) + 1;

    // command fields
    logic                c_load, c_steep;
    logic signed [C-1:0] c_maj_s, c_maj_e, c_min_s;
    logic signed [C+1:0] c_step2;
    logic [C+1:0]        c_span2;

    // line state
    logic                r_active, r_steep, r_ok;
    logic signed [C-1:0] r_maj_pos, r_maj_end, r_min_base;
    logic signed [C+1:0] r_qf, r_step2;
    logic [C+1:0]        r_span2;
    logic signed [C+2:0] r_rf;
    logic signed [NW-1:0] r_num;

    // output register
    logic                r_ovalid, r_in, r_all, r_last;
    logic signed [C-1:0] r_px, r_py;

    logic                out_free, pop, emit, is_last, in_canvas;
    logic signed [C+1:0] q, minor_w;
    logic signed [C-1:0] minor, px, py;
    logic signed [C+2:0] rf_sum, span_e;
    logic [CW-1:0]       px_u, py_u, w_u, h_u;

    assign {c_load, c_steep, c_maj_s, c_maj_e, c_min_s, c_step2, c_span2} = i_cmd;

    always_comb begin
        out_free = !r_ovalid || i_ready;
        o_cmd_ready = c_load || !r_active || out_free;
        pop  = i_cmd_valid && o_cmd_ready;
        emit = pop && !c_load && r_active;

        q = r_qf + (((r_num < 0) && (r_rf != '0)) ? (C+2)'(1) : (C+2)'(0));
        minor_w = $signed({{2{r_min_base[C-1]}}, r_min_base}) + q;
        minor = minor_w[C-1:0];
        px = r_steep ? minor : r_maj_pos;
        py = r_steep ? r_maj_pos : minor;
        px_u = CW'($unsigned(px));
        py_u = CW'($unsigned(py));
        w_u  = CW'(i_canvas_width);
        h_u  = CW'(i_canvas_height);
        in_canvas = !px[C-1] && !py[C-1] && (px_u < w_u) && (py_u < h_u);
        is_last = (r_maj_pos >= r_maj_end);

        span_e = $signed({1'b0, r_span2});
        rf_sum = r_rf + $signed({r_step2[C+1], r_step2});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_ok     <= 1'b1;
            r_ovalid <= 1'b0;
        end else begin
            if (out_free) r_ovalid <= emit;
            if (pop && c_load) begin
                r_active <= 1'b1;
                r_ok     <= 1'b1;
            end else if (emit) begin
                r_ok <= r_ok && in_canvas;
                if (is_last) r_active <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && c_load) begin
            r_steep    <= c_steep;
            r_maj_pos  <= c_maj_s;
            r_maj_end  <= c_maj_e;
            r_min_base <= c_min_s;
            r_step2    <= c_step2;
            r_span2    <= c_span2;
            r_qf       <= '0;
            r_rf       <= $signed({2'b00, c_span2[C+1:1]});
            r_num      <= $signed(NW'(c_span2[C+1:1]));
        end else if (emit && !is_last) begin
            r_maj_pos <= r_maj_pos + C'(1);
            r_num     <= r_num + NW'(r_step2);
            if (rf_sum >= span_e) begin
                r_rf <= rf_sum - span_e;
                r_qf <= r_qf + (C+2)'(1);
            end else if (rf_sum < 0) begin
                r_rf <= rf_sum + span_e;
                r_qf <= r_qf - (C+2)'(1);
            end else begin
                r_rf <= rf_sum;
            end
        end
        if (emit && out_free) begin
            r_px   <= px;
            r_py   <= py;
            r_in   <= in_canvas;
            r_all  <= r_ok && in_canvas;
            r_last <= is_last;
        end
    end

    assign o_valid      = r_ovalid;
    assign o_pixel_x    = r_px;
    assign o_pixel_y    = r_py;
    assign o_inside_res = r_in;
    assign o_all_inside = r_all;
    assign o_last       = r_last;

endmodule

### tb/sv/line_rasterizer_unit_test.sv
// Self-checking testbench for the line rasterizer: line commands, pixel ticks and canvas writes.
`timescale 1ns / 1ps

module line_rasterizer_unit_test;
    import lr_pkg::*;

    localparam int CB    = COORD_BITS_DEF;
    localparam int IN_W  = ((4*CB+7)/8)*8;
    localparam int OUT_W = ((2*CB+2+7)/8)*8;
    localparam int ITEMS_PER_PHASE = 310;

    typedef struct {
        logic signed [CB-1:0] x;
        logic signed [CB-1:0] y;
        logic                 in_canvas;
        logic                 all_in;
        logic                 last;
    } t_pixel;

    class line_pixel_tracker;
        int     canvas_w = int'(CANVAS_WIDTH_RST);
        int     canvas_h = int'(CANVAS_HEIGHT_RST);
        bit     drawing;
        bit     steep;
        int     major_pos;
        int     major_end;
        int     minor_base;
        int     steps_done;
        int     minor_step2;
        int     major_span2;
        bit     ok_so_far = 1'b1;
        t_pixel pending_pixels[$];
        int     errors;

        function void set_canvas(t_cfg_idx idx, logic [CANVAS_BITS-1:0] v);
            if (idx == CFG_CANVAS_WIDTH) begin
                canvas_w = int'(v);
            end else begin
                canvas_h = int'(v);
            end
        endfunction

        function int pending();
            return pending_pixels.size();
        endfunction

        function void take_command(t_mode m, logic [IN_W-1:0] d);
            int     sx, sy, ex, ey, adx, ady;
            int     maj_s, min_s, maj_e, min_e, t;
            int     q, minor, px, py;
            bit     in_canvas;
            t_pixel p;
            if (m == MODE_LOAD) begin
                sx = $signed(d[CB-1:0]);
                sy = $signed(d[2*CB-1:CB]);
                ex = $signed(d[3*CB-1:2*CB]);
                ey = $signed(d[4*CB-1:3*CB]);
                adx = (ex > sx) ? ex - sx : sx - ex;
                ady = (ey > sy) ? ey - sy : sy - ey;
                steep = ady > adx;
                if (steep) begin
                    maj_s = sy; min_s = sx; maj_e = ey; min_e = ex;
                end else begin
                    maj_s = sx; min_s = sy; maj_e = ex; min_e = ey;
                end
                // start from the lower major coordinate; the end wins a tie
                if (!(maj_s < maj_e)) begin
                    t = maj_s; maj_s = maj_e; maj_e = t;
                    t = min_s; min_s = min_e; min_e = t;
                end
                major_pos   = maj_s;
                major_end   = maj_e;
                minor_base  = min_s;
                steps_done  = 0;
                minor_step2 = 2 * (min_e - min_s);
                major_span2 = 2 * (maj_e - maj_s);
                ok_so_far   = 1'b1;
                drawing     = 1'b1;
                return;
            end
            if (!drawing) return;
            q = 0;
            if (major_span2 > 0) begin
                q = (minor_step2 * steps_done + major_span2 / 2) / major_span2;
            end
            minor = minor_base + q;
            px = steep ? minor : major_pos;
            py = steep ? major_pos : minor;
            in_canvas = px >= 0 && py >= 0 && px < canvas_w && py < canvas_h;
            ok_so_far = ok_so_far && in_canvas;
            p.x         = CB'(px);
            p.y         = CB'(py);
            p.in_canvas = in_canvas;
            p.all_in    = ok_so_far;
            p.last      = major_pos >= major_end;
            pending_pixels.push_back(p);
            if (p.last) begin
                drawing = 1'b0;
            end else begin
                major_pos++;
                steps_done++;
            end
        endfunction

        function void compare_field(string name, logic signed [31:0] expv,
                                    logic signed [31:0] actv);
            if (actv !== expv) begin
                $error("%s mismatch: expected %0d, got %0d", name, expv, actv);
                errors++;
            end
        endfunction

        function void check_pixel(logic [OUT_W-1:0] d, logic l);
            t_pixel e;
            if (pending_pixels.size() == 0) begin
                $error("pixel beat with none expected: x=%0d y=%0d",
                       $signed(d[CB-1:0]), $signed(d[2*CB-1:CB]));
                errors++;
                return;
            end
            e = pending_pixels.pop_front();
            compare_field("pixel_x", e.x, $signed(d[CB-1:0]));
            compare_field("pixel_y", e.y, $signed(d[2*CB-1:CB]));
            compare_field("inside_res", e.in_canvas, d[2*CB]);
            compare_field("all_inside", e.all_in, d[2*CB+1]);
            compare_field("last", e.last, l);
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic [IN_W-1:0]         i_s_tdata = '0;
    logic                    i_s_tuser = 1'b0;
    logic                    i_s_tvalid = 1'b0;
    logic                    o_s_tready;
    logic [OUT_W-1:0]        o_m_tdata;
    logic                    o_m_tlast;
    logic                    o_m_tvalid;
    logic                    i_m_tready = 1'b0;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_IDX_BITS-1:0] i_cfg_index = '0;
    logic [CANVAS_BITS-1:0]  i_cfg_data = '0;

    line_pixel_tracker tracker = new;
    int burst_left = 1;

    line_rasterizer_unit #(.COORD_BITS(CB)) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    initial begin
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            tracker.check_pixel(o_m_tdata, o_m_tlast);
        end
    end

    // Receiver: stall patterns, with a long hold-off every few rounds
    initial begin
        int style, span, k, rounds;
        rounds = 0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            rounds++;
            if (rounds % 8 == 3) begin
                i_m_tready <= 1'b0;
                repeat (300) @(posedge i_clk);
            end else begin
                style = $urandom_range(0, 3);
                span  = $urandom_range(20, 200);
                for (k = 0; k < span; k++) begin
                    case (style)
                        0: i_m_tready <= 1'b1;
                        1: i_m_tready <= 1'($urandom_range(0, 1));
                        2: i_m_tready <= ($urandom_range(0, 3) == 0);
                        default: i_m_tready <= (k % 5 < 3);
                    endcase
                    @(posedge i_clk);
                end
            end
        end
    end

    function automatic logic [IN_W-1:0] noise_word();
        return IN_W'({$urandom(), $urandom()});
    endfunction

    function automatic int rand_coord();
        return $signed(CB'($urandom()));
    endfunction

    function automatic int clamp_coord(int v);
        if (v < -(1 << (CB-1))) return -(1 << (CB-1));
        if (v > (1 << (CB-1)) - 1) return (1 << (CB-1)) - 1;
        return v;
    endfunction

    task automatic send_beat(t_mode m, logic [IN_W-1:0] d);
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= m;
        i_s_tdata  <= d;
        do @(posedge i_clk); while (!o_s_tready);
        tracker.take_command(m, d);
        burst_left--;
        if (burst_left <= 0) begin
            if ($urandom_range(0, 3) != 0) begin
                i_s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
    endtask

    task automatic send_line(int sx, int sy, int ex, int ey, int ticks);
        send_beat(MODE_LOAD, IN_W'({CB'(ey), CB'(ex), CB'(sy), CB'(sx)}));
        repeat (ticks) send_beat(MODE_TICK, noise_word());
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CANVAS_BITS-1:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        tracker.set_canvas(idx, v);
    endtask

    task automatic write_canvas(logic [CANVAS_BITS-1:0] w, logic [CANVAS_BITS-1:0] h);
        i_s_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        write_reg(CFG_CANVAS_WIDTH, w);
        write_reg(CFG_CANVAS_HEIGHT, h);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int phase_w[6];
        int phase_h[6];
        int phase, phase_items, pick, sx, sy, ex, ey, adx, ady, n, ticks;
        phase_w = '{1, 2048, 2048, 1, 0, 0};
        phase_h = '{1, 2048, 1, 2048, 0, 0};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_beat(MODE_TICK, noise_word());
        send_line(0, 0, 0, 0, 2);
        send_line(5, 3, 5, 0, 4);
        send_line(639, 479, 636, 478, 4);
        send_line(-2048, 2047, 2047, -2048, 3);
        send_line(2047, 2047, 2047, 2047, 1);
        send_line(0, 0, 3, -3, 5);

        for (phase = 0; phase < 6; phase++) begin
            if (phase_w[phase] == 0) begin
                phase_w[phase] = $urandom_range(1, 2048);
                phase_h[phase] = $urandom_range(1, 2048);
            end
            write_canvas(CANVAS_BITS'(phase_w[phase]), CANVAS_BITS'(phase_h[phase]));
            phase_items = 0;
            while (phase_items < ITEMS_PER_PHASE) begin
                pick = $urandom_range(0, 99);
                if (pick < 4) begin
                    send_beat(MODE_TICK, noise_word());
                end else begin
                    if (pick < 12) begin
                        sx = rand_coord(); sy = rand_coord();
                        ex = rand_coord(); ey = rand_coord();
                    end else begin
                        if ($urandom_range(0, 1) == 1) begin
                            sx = int'($urandom_range(0, tracker.canvas_w + 3)) - 2;
                            sy = int'($urandom_range(0, tracker.canvas_h + 3)) - 2;
                        end else begin
                            sx = rand_coord();
                            sy = rand_coord();
                        end
                        ex = clamp_coord(sx + int'($urandom_range(0, 30)) - 15);
                        ey = clamp_coord(sy + int'($urandom_range(0, 30)) - 15);
                    end
                    adx = (ex > sx) ? ex - sx : sx - ex;
                    ady = (ey > sy) ? ey - sy : sy - ey;
                    n = ((adx > ady) ? adx : ady) + 1;
                    pick = $urandom_range(0, 9);
                    if (n > 40) ticks = $urandom_range(0, 40);
                    else if (pick == 0) ticks = $urandom_range(0, n - 1);
                    else if (pick == 1) ticks = n + $urandom_range(1, 3);
                    else ticks = n;
                    send_line(sx, sy, ex, ey, ticks);
                    phase_items += 1 + ((ticks < n) ? ticks : n);
                end
            end
        end

        i_s_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (tracker.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

### filelist.f
hw/rtl/lr_pkg.sv
hw/rtl/lr_front.sv
hw/rtl/lr_fifo.sv
hw/rtl/lr_back.sv
hw/rtl/line_rasterizer_unit.sv
tb/sv/line_rasterizer_unit_test.sv
